// File: rtl/core/tdlp_pkg.sv
`default_nettype none

package tdlp_pkg;

   localparam int MAX_LINE   = 20;
   localparam int LINE_LEN_W = $clog2(MAX_LINE + 1);

   localparam int TEMP_W  = 14;
   localparam int DEPTH_W = 18;
   localparam int ACC_W   = 17;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      FLD_NONE = 2'd0,
      FLD_T    = 2'd1,
      FLD_D    = 2'd2
   } field_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_EQ         = 3'd1,
      PH_SIGN       = 3'd2,
      PH_AFTER_SIGN = 3'd3,
      PH_INT        = 3'd4,
      PH_FRAC       = 3'd5,
      PH_DONE       = 3'd6,
      PH_BAD        = 3'd7
   } phase_type;

endpackage

`default_nettype wire

// File: rtl/core/temp_depth_line_parser.sv
`default_nettype none

// Channel  Dir  Ports                                        Beat
// req      in   req_valid, req_ready, req_rx_byte            one ASCII character
// rsp      out  rsp_valid, rsp_ready, rsp_temperature_centi,  one result per CR
//               rsp_depth_centi, rsp_temp_updated, rsp_depth_updated
//
// One character per cycle while req_ready is high: each beat is parsed by
// combinational logic in front of the line state and the result register.
// A CR beat loads the result register; it shows on rsp the next cycle.
// req_ready drops only while a result waits and rsp_ready is low.
// Synchronous reset clears the line state, both value stores and rsp_valid.

module temp_depth_line_parser
   import tdlp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_rx_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic        [TEMP_W-1:0]       rsp_temperature_centi,
   output logic signed [DEPTH_W-1:0]      rsp_depth_centi,
   output logic                           rsp_temp_updated,
   output logic                           rsp_depth_updated
);

   field_type                field_ff, field_in;
   phase_type                phase_ff, phase_in;
   logic                     neg_ff, neg_in;
   logic [1:0]               int_cnt_ff, int_cnt_in;
   logic [1:0]               frac_cnt_ff, frac_cnt_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [LINE_LEN_W-1:0]    line_len_ff, line_len_in;
   logic [1:0]               ok_ff, ok_in;
   logic [TEMP_W-1:0]        temp_store_ff, temp_store_in;
   logic [DEPTH_W-1:0]       depth_store_ff, depth_store_in;
   logic [TEMP_W-1:0]        pend_temp_ff, pend_temp_in;
   logic [DEPTH_W-1:0]       pend_depth_ff, pend_depth_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_flags_ff, rsp_flags_in;

   logic                     accept;
   logic                     is_digit, is_cr, is_t, is_d;
   logic [3:0]               digit_val;
   logic                     do_close;
   logic [1:0]               int_limit;
   logic [20:0]              acc_mac;
   logic [DEPTH_W-1:0]       acc_ext;
   logic [1:0]               ok_closed;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_digit  = (req_rx_byte >= CHAR_ZERO) && (req_rx_byte <= CHAR_NINE);
   assign digit_val = is_digit ? req_rx_byte[3:0] : 4'd0;
   assign is_cr     = (req_rx_byte == CHAR_CR);
   assign is_t      = (req_rx_byte == CHAR_T);
   assign is_d      = (req_rx_byte == CHAR_D);

   // a complete field ends on any non-digit (CR, T and D included)
   assign do_close  = (phase_ff == PH_DONE) && !is_digit;
   assign int_limit = (field_ff == FLD_D && !neg_ff) ? 2'd3 : 2'd2;
   assign acc_mac   = 21'(acc_ff) * 21'd10 + 21'(digit_val);
   assign acc_ext   = {1'b0, acc_ff};

   always_comb begin
      ok_closed = ok_ff;
      if (do_close && field_ff == FLD_T) begin
         ok_closed[0] = 1'b1;
      end
      if (do_close && field_ff == FLD_D) begin
         ok_closed[1] = 1'b1;
      end
   end

   // next state of the field parser
   always_comb begin
      field_in = field_ff;
      phase_in = phase_ff;
      if (accept) begin
         if (is_cr) begin
            field_in = FLD_NONE;
            phase_in = PH_IDLE;
         end else if (is_t || is_d) begin
            field_in = is_t ? FLD_T : FLD_D;
            phase_in = PH_EQ;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_EQ: begin
                  phase_in = (req_rx_byte == CHAR_EQ) ? PH_SIGN : PH_BAD;
               end
               PH_SIGN, PH_AFTER_SIGN: begin
                  if (is_digit) begin
                     phase_in = PH_INT;
                  end else if (phase_ff == PH_SIGN && field_ff == FLD_D &&
                               req_rx_byte == CHAR_MINUS) begin
                     phase_in = PH_AFTER_SIGN;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_INT: begin
                  if (is_digit && int_cnt_ff < int_limit) begin
                     phase_in = PH_INT;
                  end else if (req_rx_byte == CHAR_DOT) begin
                     phase_in = PH_FRAC;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_FRAC: begin
                  if (!is_digit) begin
                     phase_in = PH_BAD;
                  end else if (frac_cnt_ff != 2'd0) begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DONE: begin
                  if (is_digit) begin
                     phase_in = PH_BAD;
                  end else begin
                     field_in = FLD_NONE;
                     phase_in = PH_IDLE;
                  end
               end
               PH_BAD: begin
               end
            endcase
         end
      end
   end

   // datapath, line bookkeeping and result
   always_comb begin
      neg_in         = neg_ff;
      int_cnt_in     = int_cnt_ff;
      frac_cnt_in    = frac_cnt_ff;
      acc_in         = acc_ff;
      line_len_in    = line_len_ff;
      ok_in          = ok_ff;
      temp_store_in  = temp_store_ff;
      depth_store_in = depth_store_ff;
      pend_temp_in   = pend_temp_ff;
      pend_depth_in  = pend_depth_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_flags_in   = rsp_flags_ff;

      if (accept) begin
         if (do_close && field_ff == FLD_T) begin
            pend_temp_in = acc_ff[TEMP_W-1:0];
         end
         if (do_close && field_ff == FLD_D) begin
            pend_depth_in = neg_ff ? -acc_ext : acc_ext;
         end

         if (is_cr) begin
            if (line_len_ff >= LINE_LEN_W'(MAX_LINE)) begin
               rsp_flags_in = 2'b00;
            end else begin
               rsp_flags_in = ok_closed;
            end
            if (rsp_flags_in[0]) begin
               temp_store_in = pend_temp_in;
            end
            if (rsp_flags_in[1]) begin
               depth_store_in = pend_depth_in;
            end
            rsp_valid_in = 1'b1;
            neg_in       = 1'b0;
            int_cnt_in   = 2'd0;
            frac_cnt_in  = 2'd0;
            acc_in       = '0;
            line_len_in  = '0;
            ok_in        = 2'b00;
         end else begin
            if (line_len_ff < LINE_LEN_W'(MAX_LINE)) begin
               line_len_in = line_len_ff + LINE_LEN_W'(1);
            end
            if (is_t || is_d) begin
               ok_in       = ok_closed & (is_t ? 2'b10 : 2'b01);
               neg_in      = 1'b0;
               int_cnt_in  = 2'd0;
               frac_cnt_in = 2'd0;
               acc_in      = '0;
            end else begin
               ok_in = ok_closed;
               case (phase_ff)
                  PH_SIGN, PH_AFTER_SIGN: begin
                     if (is_digit) begin
                        acc_in     = ACC_W'(digit_val);
                        int_cnt_in = 2'd1;
                     end else if (phase_ff == PH_SIGN && field_ff == FLD_D &&
                                  req_rx_byte == CHAR_MINUS) begin
                        neg_in = 1'b1;
                     end
                  end
                  PH_INT: begin
                     if (is_digit && int_cnt_ff < int_limit) begin
                        acc_in     = acc_mac[ACC_W-1:0];
                        int_cnt_in = int_cnt_ff + 2'd1;
                     end
                  end
                  PH_FRAC: begin
                     if (is_digit) begin
                        acc_in      = acc_mac[ACC_W-1:0];
                        frac_cnt_in = frac_cnt_ff + 2'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff       <= FLD_NONE;
         phase_ff       <= PH_IDLE;
         neg_ff         <= 1'b0;
         int_cnt_ff     <= 2'd0;
         frac_cnt_ff    <= 2'd0;
         acc_ff         <= '0;
         line_len_ff    <= '0;
         ok_ff          <= 2'b00;
         temp_store_ff  <= '0;
         depth_store_ff <= '0;
         pend_temp_ff   <= '0;
         pend_depth_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         field_ff       <= field_in;
         phase_ff       <= phase_in;
         neg_ff         <= neg_in;
         int_cnt_ff     <= int_cnt_in;
         frac_cnt_ff    <= frac_cnt_in;
         acc_ff         <= acc_in;
         line_len_ff    <= line_len_in;
         ok_ff          <= ok_in;
         temp_store_ff  <= temp_store_in;
         depth_store_ff <= depth_store_in;
         pend_temp_ff   <= pend_temp_in;
         pend_depth_ff  <= pend_depth_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flags_ff <= rsp_flags_in;
   end

   // stores only move on a CR beat, which also reloads the result
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = temp_store_ff;
   assign rsp_depth_centi       = depth_store_ff;
   assign rsp_temp_updated      = rsp_flags_ff[0];
   assign rsp_depth_updated     = rsp_flags_ff[1];

   a_cr_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && is_cr |=> rsp_valid_ff)
      else $error("CR beat did not load a result");

   a_stores_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && is_cr) |=> $stable(temp_store_ff) && $stable(depth_store_ff))
      else $error("value store changed without a CR beat");

   a_idle_no_field: assert property (@(posedge clock) disable iff (reset)
      (field_ff == FLD_NONE) == (phase_ff == PH_IDLE))
      else $error("field and phase out of step");

   a_done_two_frac: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> frac_cnt_ff == 2'd2)
      else $error("field complete without two fraction digits");

   a_len_sat: assert property (@(posedge clock) disable iff (reset)
      line_len_ff <= LINE_LEN_W'(MAX_LINE))
      else $error("line length past saturation");

endmodule

`default_nettype wire
